### rtl/l2pe_pkg.sv
// Shared types and constants for the 2D lattice partial Euclid reducer.
`timescale 1ns / 1ps
package l2pe_pkg;

    localparam int IO_WIDTH = 32;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_ITER = 2'd2;
    localparam logic [1:0] ERR_OVF  = 2'd3;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_DIV_START,
        OP_MUL1,
        OP_MUL2,
        OP_UPDATE,
        OP_FIX,
        OP_SWAP,
        OP_NORM,
        OP_FQ_PREP,
        OP_FQ_MUL1,
        OP_FQ_MUL2,
        OP_FQ_CAND,
        OP_FQ_PICK
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic       div_busy;
        logic       ovf;
        logic       res_ovf;
        logic       in_ovf;
        logic       reduced;
        logic       div_zero;
        logic       stop;
        logic       fq_zero;
        logic       fq_div0;
    } dp_stat_t;

endpackage

### rtl/lattice2d_partial_euclid_reduce_core.sv
// Top level of the 2D lattice basis reducer (partial Euclid, max norm).
`timescale 1ns / 1ps
// Reduces one two-dimensional basis per item in the maximum norm. Each item
// is accepted while the block is idle and its result is held until taken;
// the next item is accepted once the result leaves. The divider width W is
// max(COORD_WIDTH, 32) + 2. Every Euclid exchange and the final quotient
// step runs one truncating division on a shared one-bit-per-cycle divider
// and two registered multiplies.
module lattice2d_partial_euclid_reduce_core
    import l2pe_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int MAX_STEPS   = 255
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [IO_WIDTH-1:0] vec_a_x,
    input  logic signed [IO_WIDTH-1:0] vec_a_y,
    input  logic signed [IO_WIDTH-1:0] vec_b_x,
    input  logic signed [IO_WIDTH-1:0] vec_b_y,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [IO_WIDTH-1:0] red_a_x,
    output logic signed [IO_WIDTH-1:0] red_a_y,
    output logic signed [IO_WIDTH-1:0] red_b_x,
    output logic signed [IO_WIDTH-1:0] red_b_y,
    output logic [7:0]                 step_count,
    output logic [1:0]                 error_code
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     sel_in;
    logic signed [IO_WIDTH-1:0] ra_x, ra_y, rb_x, rb_y, ia_x, ia_y, ib_x, ib_y;

    l2pe_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .sel_in    (sel_in),
        .steps     (step_count),
        .err       (error_code)
    );

    l2pe_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .vec_a_x (vec_a_x),
        .vec_a_y (vec_a_y),
        .vec_b_x (vec_b_x),
        .vec_b_y (vec_b_y),
        .stat    (stat),
        .res_a_x (ra_x),
        .res_a_y (ra_y),
        .res_b_x (rb_x),
        .res_b_y (rb_y),
        .in_a_x  (ia_x),
        .in_a_y  (ia_y),
        .in_b_x  (ib_x),
        .in_b_y  (ib_y)
    );

    // On error repeat the input basis
    assign red_a_x = sel_in ? ia_x : ra_x;
    assign red_a_y = sel_in ? ia_y : ra_y;
    assign red_b_x = sel_in ? ib_x : rb_x;
    assign red_b_y = sel_in ? ib_y : rb_y;

endmodule

### rtl/l2pe_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module l2pe_div
    import l2pe_pkg::*;
#(
    parameter int W = 33
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;

    // Shift in one dividend bit and try a subtraction
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, dsr_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### rtl/l2pe_datapath.sv
// Datapath: coordinate registers, divider, multiplier and overflow checks.
`timescale 1ns / 1ps
module l2pe_datapath
    import l2pe_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    input  logic signed [IO_WIDTH-1:0] vec_a_x,
    input  logic signed [IO_WIDTH-1:0] vec_a_y,
    input  logic signed [IO_WIDTH-1:0] vec_b_x,
    input  logic signed [IO_WIDTH-1:0] vec_b_y,
    output dp_stat_t                   stat,
    output logic signed [IO_WIDTH-1:0] res_a_x,
    output logic signed [IO_WIDTH-1:0] res_a_y,
    output logic signed [IO_WIDTH-1:0] res_b_x,
    output logic signed [IO_WIDTH-1:0] res_b_y,
    output logic signed [IO_WIDTH-1:0] in_a_x,
    output logic signed [IO_WIDTH-1:0] in_a_y,
    output logic signed [IO_WIDTH-1:0] in_b_x,
    output logic signed [IO_WIDTH-1:0] in_b_y
);

    // Internal width: wide enough for the inputs and two guard bits
    localparam int CW  = COORD_WIDTH;
    localparam int XW  = ((CW > IO_WIDTH) ? CW : IO_WIDTH) + 2;
    localparam int PW  = 2 * XW;

    typedef logic signed [XW-1:0] xv_t;

    localparam xv_t HI = xv_t'((XW'(1) << (CW - 1)) - 1);
    localparam xv_t LO = -HI - xv_t'(1);

    xv_t ia_x_reg, ia_y_reg, ib_x_reg, ib_y_reg;
    xv_t r0_reg, r1_reg, p0_reg, p1_reg, r0_next, r1_next, p0_next, p1_next;
    xv_t q_reg, q_next;
    xv_t m1_reg, m2_reg, m1_next, m2_next;
    xv_t t2x_reg, t2y_reg, t2x_next, t2y_next;
    logic flag_reg, flag_next, br_reg, br_next;
    logic ovf_reg, ovf_next, stop_reg, stop_next;
    logic in_ovf_reg, in_ovf_next, red_reg, red_next;
    logic fqz_reg, fqz_next, fqd0_reg, fqd0_next;
    logic qneg_reg, qneg_next;

    function automatic logic rng(input xv_t v);
        return (v < LO) || (v > HI);
    endfunction

    function automatic xv_t mg(input xv_t v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [1:0] sg(input xv_t v);
        return (v > 0) ? 2'sd1 : ((v < 0) ? -2'sd1 : 2'sd0);
    endfunction

    // Divider shared by exchange and final quotient
    logic           div_start;
    logic [XW-1:0]  div_dvd, div_dsr, div_q;
    logic           div_busy;
    logic           dneg_reg, dneg_next;
    xv_t            dvd_sel, dsr_sel;

    l2pe_div #(.W(XW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // One signed multiplier, operands chosen by the command
    xv_t mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_reg;
    assign prod = mul_a * mul_b;

    xv_t prod_x;
    logic prod_ovf;
    always_comb
    begin
        prod_x   = xv_t'(prod_reg);
        prod_ovf = (prod_reg < PW'(LO)) || (prod_reg > PW'(HI));
    end

    logic br_take;
    logic zero_any;
    logic flip0, flip1;
    xv_t  nr1, np1, d_x, d_y, s_x, s_y, mx0, mx1;
    logic [2:0] nc;

    always_comb
    begin
        r0_next = r0_reg; r1_next = r1_reg; p0_next = p0_reg; p1_next = p1_reg;
        q_next = q_reg; m1_next = m1_reg; m2_next = m2_reg;
        t2x_next = t2x_reg; t2y_next = t2y_reg;
        flag_next = flag_reg; br_next = br_reg; ovf_next = ovf_reg;
        stop_next = stop_reg; in_ovf_next = in_ovf_reg; red_next = red_reg;
        fqz_next = fqz_reg; fqd0_next = fqd0_reg; qneg_next = qneg_reg;
        dneg_next = dneg_reg;
        div_start = 1'b0;
        dvd_sel = '0; dsr_sel = '1;
        mul_a = q_reg; mul_b = r1_reg;
        br_take = (mg(r0_reg) >= mg(p0_reg)) && (r1_reg != 0);
        nc = 3'(r0_reg < 0) + 3'(p0_reg < 0) + 3'(r1_reg < 0) + 3'(p1_reg < 0);
        zero_any = (r0_reg == 0) || (p0_reg == 0) || (r1_reg == 0) || (p1_reg == 0);
        nr1 = -r1_reg; np1 = -p1_reg;
        flip0 = 1'b0; flip1 = 1'b0;
        d_x = '0; d_y = '0; s_x = '0; s_y = '0; mx0 = '0; mx1 = '0;
        unique case (cmd.op)
            OP_LOAD:
            begin
                // Registers mirror the inputs; r=x, p=y
                r0_next = xv_t'(vec_a_x); p0_next = xv_t'(vec_a_y);
                r1_next = xv_t'(vec_b_x); p1_next = xv_t'(vec_b_y);
                in_ovf_next = rng(xv_t'(vec_a_x)) || rng(xv_t'(vec_a_y)) ||
                              rng(xv_t'(vec_b_x)) || rng(xv_t'(vec_b_y));
                ovf_next = 1'b0; flag_next = 1'b0; stop_next = 1'b0;
                red_next = 1'b0; fqz_next = 1'b0; fqd0_next = 1'b0;
            end
            OP_PREP:
            begin
                // Early exit test and opposite-sign fix
                if (zero_any || nc[0])
                begin
                    flag_next = 1'b1;
                    red_next = ((mg(r0_reg) >= mg(p0_reg)) && (mg(r1_reg) <= mg(p1_reg))) ||
                               ((mg(r0_reg) <= mg(p0_reg)) && (mg(r1_reg) >= mg(p1_reg)));
                end
                else if (sg(r0_reg) != sg(r1_reg))
                begin
                    r1_next = nr1; p1_next = np1;
                    ovf_next = rng(nr1) || rng(np1);
                end
            end
            OP_DIV_START:
            begin
                // Choose branch and launch magnitude divide
                br_next = br_take;
                if (br_take)
                begin
                    dvd_sel = r0_reg; dsr_sel = r1_reg;
                end
                else
                begin
                    dvd_sel = p0_reg; dsr_sel = p1_reg;
                end
                dneg_next = (dvd_sel < 0) != (dsr_sel < 0);
                div_start = br_take || (p1_reg != 0);
            end
            OP_MUL1:
            begin
                // Latch the signed quotient and start q*r1
                q_next = dneg_reg ? -xv_t'(div_q) : xv_t'(div_q);
                ovf_next = ovf_reg || rng(dneg_reg ? -xv_t'(div_q) : xv_t'(div_q));
                mul_a = q_next; mul_b = r1_reg;
            end
            OP_MUL2:
            begin
                // Product q*r1 registered; start q*p1
                mul_a = q_reg; mul_b = p1_reg;
                m1_next = prod_x;
                ovf_next = ovf_reg || prod_ovf;
            end
            OP_UPDATE:
            begin
                mul_a = q_reg; mul_b = p1_reg;
                d_x = r0_reg - m1_reg;
                d_y = p0_reg - prod_x;
                ovf_next = ovf_reg || prod_ovf || rng(d_x) || rng(d_y);
                r0_next = d_x; p0_next = d_y;
            end
            OP_FIX:
            begin
                // Sign-crossing flag and forced extra subtraction
                if (br_reg)
                begin
                    if (!flag_reg && sg(p1_reg) != sg(p0_reg)) flag_next = 1'b1;
                    else if (!flag_reg && mg(p1_reg) <= mg(p0_reg))
                    begin
                        d_x = r0_reg - r1_reg; d_y = p0_reg - p1_reg;
                        r0_next = d_x; p0_next = d_y; flag_next = 1'b1;
                        ovf_next = ovf_reg || rng(d_x) || rng(d_y);
                    end
                end
                else
                begin
                    if (!flag_reg && sg(r1_reg) != sg(r0_reg)) flag_next = 1'b1;
                    else if (!flag_reg && mg(r1_reg) <= mg(r0_reg))
                    begin
                        d_x = r0_reg - r1_reg; d_y = p0_reg - p1_reg;
                        r0_next = d_x; p0_next = d_y; flag_next = 1'b1;
                        ovf_next = ovf_reg || rng(d_x) || rng(d_y);
                    end
                end
            end
            OP_SWAP:
            begin
                r0_next = r1_reg; r1_next = r0_reg;
                p0_next = p1_reg; p1_next = p0_reg;
                stop_next = flag_reg &&
                    (((mg(r1_reg) >= mg(p1_reg)) && (mg(r0_reg) <= mg(p0_reg))) ||
                     ((mg(r1_reg) <= mg(p1_reg)) && (mg(r0_reg) >= mg(p0_reg))));
            end
            OP_NORM:
            begin
                // Sign normalization then order by max norm
                flip0 = ((sg(r0_reg) * sg(r1_reg)) == 0) && (sg(p0_reg) != sg(p1_reg));
                flip1 = ((sg(p0_reg) * sg(p1_reg)) == 0) && (sg(r0_reg) != sg(r1_reg));
                s_x = r1_reg; s_y = p1_reg;
                if (flip0)
                begin
                    s_x = -s_x; s_y = -s_y;
                end
                if (flip1)
                begin
                    s_x = -s_x; s_y = -s_y;
                end
                // The first negation alone decides overflow
                ovf_next = (flip0 || flip1) && (rng(nr1) || rng(np1));
                mx0 = (mg(r0_reg) >= mg(p0_reg)) ? mg(r0_reg) : mg(p0_reg);
                mx1 = (mg(s_x) >= mg(s_y)) ? mg(s_x) : mg(s_y);
                if (mx0 > mx1)
                begin
                    r0_next = s_x; p0_next = s_y; r1_next = r0_reg; p1_next = p0_reg;
                end
                else
                begin
                    r1_next = s_x; p1_next = s_y;
                end
            end
            OP_FQ_PREP:
            begin
                // Final quotient dividend and divisor
                fqz_next = (r0_reg == 0) && (p0_reg == 0);
                if ((sg(p0_reg) * sg(p1_reg)) <= 0) d_x = mg(r1_reg) - mg(p1_reg);
                else d_x = mg(p1_reg) - mg(r1_reg);
                d_y = mg(p0_reg) + mg(r0_reg);
                ovf_next = !fqz_next && (rng(d_x) || rng(d_y) ||
                           rng(mg(r0_reg)) || rng(mg(p0_reg)) ||
                           rng(mg(r1_reg)) || rng(mg(p1_reg)));
                fqd0_next = !fqz_next && (d_y == 0);
                dvd_sel = d_x; dsr_sel = d_y;
                dneg_next = (d_x < 0) != (d_y < 0);
                div_start = !fqz_next && (d_y != 0);
            end
            OP_FQ_MUL1:
            begin
                q_next = dneg_reg ? -xv_t'(div_q) : xv_t'(div_q);
                qneg_next = dneg_reg && (div_q != 0);
                ovf_next = ovf_reg || rng(dneg_reg ? -xv_t'(div_q) : xv_t'(div_q));
                mul_a = q_next; mul_b = r0_reg;
            end
            OP_FQ_MUL2:
            begin
                mul_a = q_reg; mul_b = p0_reg;
                m1_next = prod_x;
                ovf_next = ovf_reg || prod_ovf;
            end
            OP_FQ_CAND:
            begin
                mul_a = q_reg; mul_b = p0_reg;
                d_x = r1_reg - m1_reg;
                d_y = p1_reg - prod_x;
                ovf_next = ovf_reg || prod_ovf || rng(d_x) || rng(d_y);
                m1_next = d_x; m2_next = d_y;
                if (!qneg_reg)
                begin
                    t2x_next = d_x - r0_reg; t2y_next = d_y - p0_reg;
                end
                else
                begin
                    t2x_next = d_x + r0_reg; t2y_next = d_y + p0_reg;
                end
            end
            OP_FQ_PICK:
            begin
                // Keep the shorter candidate in r1/p1
                ovf_next = ovf_reg || rng(t2x_reg) || rng(t2y_reg);
                mx0 = (mg(m1_reg) >= mg(m2_reg)) ? mg(m1_reg) : mg(m2_reg);
                mx1 = (mg(t2x_reg) >= mg(t2y_reg)) ? mg(t2x_reg) : mg(t2y_reg);
                if (mx0 > mx1)
                begin
                    r1_next = t2x_reg; p1_next = t2y_reg;
                end
                else
                begin
                    r1_next = m1_reg; p1_next = m2_reg;
                end
            end
            default:
            begin
            end
        endcase
        div_dvd = (dvd_sel < 0) ? XW'(-dvd_sel) : XW'(dvd_sel);
        div_dsr = (dsr_sel < 0) ? XW'(-dsr_sel) : XW'(dsr_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0; br_reg <= 1'b0; ovf_reg <= 1'b0; stop_reg <= 1'b0;
            in_ovf_reg <= 1'b0; red_reg <= 1'b0; fqz_reg <= 1'b0; fqd0_reg <= 1'b0;
            qneg_reg <= 1'b0; dneg_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next; br_reg <= br_next; ovf_reg <= ovf_next;
            stop_reg <= stop_next; in_ovf_reg <= in_ovf_next; red_reg <= red_next;
            fqz_reg <= fqz_next; fqd0_reg <= fqd0_next; qneg_reg <= qneg_next;
            dneg_reg <= dneg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next; r1_reg <= r1_next; p0_reg <= p0_next; p1_reg <= p1_next;
        q_reg <= q_next; m1_reg <= m1_next; m2_reg <= m2_next;
        t2x_reg <= t2x_next; t2y_reg <= t2y_next;
        prod_reg <= prod;
        if (cmd.op == OP_LOAD)
        begin
            ia_x_reg <= xv_t'(vec_a_x); ia_y_reg <= xv_t'(vec_a_y);
            ib_x_reg <= xv_t'(vec_b_x); ib_y_reg <= xv_t'(vec_b_y);
        end
    end

    localparam xv_t H32 = xv_t'(32'h7FFF_FFFF);
    localparam xv_t L32 = -H32 - xv_t'(1);

    assign stat.div_busy = div_busy;
    assign stat.ovf      = ovf_reg;
    // Result must fit the 32-bit output fields
    assign stat.res_ovf  = (r0_reg > H32) || (r0_reg < L32) || (p0_reg > H32) ||
                           (p0_reg < L32) || (r1_reg > H32) || (r1_reg < L32) ||
                           (p1_reg > H32) || (p1_reg < L32);
    assign stat.in_ovf   = in_ovf_reg;
    assign stat.reduced  = red_reg;
    assign stat.div_zero = !br_reg && (p1_reg == 0);
    assign stat.stop     = stop_reg;
    assign stat.fq_zero  = fqz_reg;
    assign stat.fq_div0  = fqd0_reg;

    assign res_a_x = IO_WIDTH'(r0_reg);
    assign res_a_y = IO_WIDTH'(p0_reg);
    assign res_b_x = IO_WIDTH'(r1_reg);
    assign res_b_y = IO_WIDTH'(p1_reg);
    assign in_a_x  = IO_WIDTH'(ia_x_reg);
    assign in_a_y  = IO_WIDTH'(ia_y_reg);
    assign in_b_x  = IO_WIDTH'(ib_x_reg);
    assign in_b_y  = IO_WIDTH'(ib_y_reg);

endmodule

### rtl/l2pe_ctrl.sv
// Controller: sequences the exchange loop, final step and result handshake.
`timescale 1ns / 1ps
module l2pe_ctrl
    import l2pe_pkg::*;
#(
    parameter int MAX_STEPS = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd,
    output logic       sel_in,
    output logic [7:0] steps,
    output logic [1:0] err
);

    localparam int SW = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_MUL1  = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_FIX   = 4'd8;
    localparam logic [3:0] S_SWAP  = 4'd9;
    localparam logic [3:0] S_NORM  = 4'd10;
    localparam logic [3:0] S_FQP   = 4'd11;
    localparam logic [3:0] S_FQW   = 4'd12;
    localparam logic [3:0] S_FQM   = 4'd13;
    localparam logic [3:0] S_FQC   = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    logic [3:0]    st_reg, st_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [1:0]    err_reg, err_next;
    logic          sel_reg, sel_next;
    logic          ov_reg, ov_next;
    logic          fq_reg, fq_next;
    logic [1:0]    sub_reg, sub_next;

    always_comb
    begin
        st_next = st_reg; cnt_next = cnt_reg; err_next = err_reg;
        sel_next = sel_reg; ov_next = ov_reg; fq_next = fq_reg; sub_next = sub_reg;
        cmd.op = OP_NONE;
        if (ov_reg && !out_stall) ov_next = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    cmd.op = OP_LOAD; cnt_next = '0; err_next = ERR_OK;
                    sel_next = 1'b0; st_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (stat.in_ovf)
                begin
                    err_next = ERR_OVF; sel_next = 1'b1; st_next = S_FIN;
                end
                else
                begin
                    cmd.op = OP_PREP; st_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (stat.reduced) st_next = S_FIN;
                else if (stat.ovf)
                begin
                    err_next = ERR_OVF; sel_next = 1'b1; st_next = S_FIN;
                end
                else if (cnt_reg >= SW'(MAX_STEPS))
                begin
                    err_next = ERR_ITER; sel_next = 1'b1; st_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1; st_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_START; st_next = S_WAIT; sub_next = 2'd0;
            end
            S_WAIT:
            begin
                // Divide by zero on the y branch
                if (stat.div_zero)
                begin
                    err_next = ERR_DIV0; sel_next = 1'b1; st_next = S_FIN;
                end
                else if (sub_reg == 2'd0) sub_next = 2'd1;
                else if (!stat.div_busy) st_next = S_MUL1;
            end
            S_MUL1: begin cmd.op = OP_MUL1; st_next = S_MUL2; end
            S_MUL2: begin cmd.op = OP_MUL2; st_next = S_UPD; end
            S_UPD:  begin cmd.op = OP_UPDATE; st_next = S_FIX; end
            S_FIX:  begin cmd.op = OP_FIX; st_next = S_SWAP; end
            S_SWAP:
            begin
                if (stat.ovf)
                begin
                    err_next = ERR_OVF; sel_next = 1'b1; st_next = S_FIN;
                end
                else
                begin
                    cmd.op = OP_SWAP; st_next = S_NORM; fq_next = 1'b0;
                end
            end
            S_NORM:
            begin
                if (!fq_reg)
                begin
                    // Loop again unless the stop test held
                    if (stat.stop)
                    begin
                        cmd.op = OP_NORM; fq_next = 1'b1;
                    end
                    else st_next = S_CHK;
                end
                else
                begin
                    if (stat.ovf)
                    begin
                        err_next = ERR_OVF; sel_next = 1'b1; st_next = S_FIN;
                    end
                    else
                    begin
                        cmd.op = OP_FQ_PREP; st_next = S_FQP;
                    end
                end
            end
            S_FQP:
            begin
                if (stat.fq_zero) st_next = S_FIN;
                else if (stat.ovf)
                begin
                    err_next = ERR_OVF; sel_next = 1'b1; st_next = S_FIN;
                end
                else if (stat.fq_div0)
                begin
                    err_next = ERR_DIV0; sel_next = 1'b1; st_next = S_FIN;
                end
                else st_next = S_FQW;
            end
            S_FQW:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op = OP_FQ_MUL1; st_next = S_FQM;
                end
            end
            S_FQM:  begin cmd.op = OP_FQ_MUL2; st_next = S_FQC; end
            S_FQC:
            begin
                if (sub_reg != 2'd3)
                begin
                    cmd.op = OP_FQ_CAND; sub_next = 2'd3;
                end
                else
                begin
                    cmd.op = OP_FQ_PICK; st_next = S_FIN; fq_next = 1'b0;
                end
            end
            S_FIN:
            begin
                // Final range check, then hand the word to the output
                if (!fq_reg)
                begin
                    fq_next = 1'b1;
                end
                else
                begin
                    if (err_reg == ERR_OK && (stat.ovf || stat.res_ovf))
                    begin
                        err_next = ERR_OVF; sel_next = 1'b1;
                    end
                    ov_next = 1'b1; st_next = S_IDLE; fq_next = 1'b0;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; cnt_reg <= '0; err_reg <= ERR_OK;
            sel_reg <= 1'b0; ov_reg <= 1'b0; fq_reg <= 1'b0; sub_reg <= 2'd0;
        end
        else
        begin
            st_reg <= st_next; cnt_reg <= cnt_next; err_reg <= err_next;
            sel_reg <= sel_next; ov_reg <= ov_next; fq_reg <= fq_next; sub_reg <= sub_next;
        end
    end

    assign in_stall  = (st_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign sel_in    = sel_reg;
    assign err       = err_reg;
    assign steps     = (cnt_reg > SW'(255)) ? 8'd255 : 8'(cnt_reg);

endmodule

### dv/l2pe_checker.sv
// Checker for the 2D lattice reducer: basis prediction and result scoreboard.
`timescale 1ns / 1ps
module l2pe_checker
    import l2pe_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic signed [IO_WIDTH-1:0] vec_a_x,
    input  logic signed [IO_WIDTH-1:0] vec_a_y,
    input  logic signed [IO_WIDTH-1:0] vec_b_x,
    input  logic signed [IO_WIDTH-1:0] vec_b_y,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [IO_WIDTH-1:0] red_a_x,
    input  logic signed [IO_WIDTH-1:0] red_a_y,
    input  logic signed [IO_WIDTH-1:0] red_b_x,
    input  logic signed [IO_WIDTH-1:0] red_b_y,
    input  logic [7:0]                 step_count,
    input  logic [1:0]                 error_code,
    output int                         fail_count,
    output int                         pending_count,
    output int                         basis_count,
    output int                         err_seen [4]
);

    localparam int    STEP_LIMIT = 255;
    localparam longint CW_HI     = 64'sd2147483647;
    localparam longint CW_LO     = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] ax, ay, bx, by;
        logic [7:0]         steps;
        logic [1:0]         err;
    } reduced_basis_t;

    reduced_basis_t expected_bases[$];
    bit             arith_ovf;

    // All values stay within 32 bits, so 64-bit arithmetic never wraps
    function automatic longint clip(longint v);
        if (v < CW_LO || v > CW_HI)
        begin
            arith_ovf = 1;
            return 0;
        end
        return v;
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int sgnl(longint v);
        return v > 0 ? 1 : (v < 0 ? -1 : 0);
    endfunction

    function automatic longint mulc(longint a, longint b);
        return clip(a * b);
    endfunction

    function automatic longint divc(longint a, longint b);
        longint m;
        m = absl(a) / absl(b);
        return clip(((a < 0) != (b < 0)) ? -m : m);
    endfunction

    function automatic reduced_basis_t pack_basis(longint ax, ay, bx, by,
                                                  int steps, logic [1:0] err);
        reduced_basis_t r;
        r.ax = ax[31:0];
        r.ay = ay[31:0];
        r.bx = bx[31:0];
        r.by = by[31:0];
        r.steps = steps > 255 ? 8'd255 : steps[7:0];
        r.err = err;
        return r;
    endfunction

    function automatic reduced_basis_t reduce_basis(longint ax, ay, bx, by);
        longint r0, r1, p0, p1, t, q, t1x, t1y, t2x, t2y, divd, disr, m1, m2;
        int steps, negs;
        logic [1:0] err;
        bit flag;
        arith_ovf = 0;
        steps = 0;
        err = ERR_OK;
        flag = 0;
        negs = (ax < 0) + (ay < 0) + (bx < 0) + (by < 0);
        if (ax == 0 || ay == 0 || bx == 0 || by == 0 || negs[0])
        begin
            flag = 1;
            if ((absl(ax) >= absl(ay) && absl(bx) <= absl(by)) ||
                (absl(ax) <= absl(ay) && absl(bx) >= absl(by)))
                return pack_basis(ax, ay, bx, by, 0, ERR_OK);
        end
        r0 = ax; r1 = bx; p0 = ay; p1 = by;
        if (!flag && sgnl(r0) != sgnl(r1))
        begin
            r1 = clip(-r1);
            p1 = clip(-p1);
        end
        if (arith_ovf)
            err = ERR_OVF;
        // Exchange on the x or y pair, chosen by magnitude, until the stop test holds or an error ends the run
        while (err == ERR_OK)
        begin
            if (steps >= STEP_LIMIT)
            begin
                err = ERR_ITER;
                break;
            end
            steps++;
            if (absl(r0) >= absl(p0) && r1 != 0)
            begin
                q = divc(r0, r1);
                r0 = clip(r0 - mulc(q, r1));
                p0 = clip(p0 - mulc(q, p1));
                if (!flag && sgnl(p1) != sgnl(p0))
                    flag = 1;
                if (!flag && absl(p1) <= absl(p0))
                begin
                    r0 = clip(r0 - r1);
                    p0 = clip(p0 - p1);
                    flag = 1;
                end
            end
            else
            begin
                if (p1 == 0)
                begin
                    err = ERR_DIV0;
                    break;
                end
                q = divc(p0, p1);
                p0 = clip(p0 - mulc(q, p1));
                r0 = clip(r0 - mulc(q, r1));
                if (!flag && sgnl(r1) != sgnl(r0))
                    flag = 1;
                if (!flag && absl(r1) <= absl(r0))
                begin
                    r0 = clip(r0 - r1);
                    p0 = clip(p0 - p1);
                    flag = 1;
                end
            end
            if (arith_ovf)
            begin
                err = ERR_OVF;
                break;
            end
            t = r0; r0 = r1; r1 = t;
            t = p0; p0 = p1; p1 = t;
            if (flag)
            begin
                if (absl(r0) >= absl(p0) && absl(r1) <= absl(p1))
                    break;
                if (absl(r0) <= absl(p0) && absl(r1) >= absl(p1))
                    break;
            end
        end
        if (err != ERR_OK)
            return pack_basis(ax, ay, bx, by, steps, err);
        // Normalize signs and order by maximum norm
        if (sgnl(r0) * sgnl(r1) == 0 && sgnl(p0) != sgnl(p1))
        begin
            r1 = clip(-r1);
            p1 = clip(-p1);
        end
        if (sgnl(p0) * sgnl(p1) == 0 && sgnl(r0) != sgnl(r1))
        begin
            r1 = clip(-r1);
            p1 = clip(-p1);
        end
        m1 = absl(r0) >= absl(p0) ? absl(r0) : absl(p0);
        m2 = absl(r1) >= absl(p1) ? absl(r1) : absl(p1);
        if (m1 > m2)
        begin
            t = r0; r0 = r1; r1 = t;
            t = p0; p0 = p1; p1 = t;
        end
        if (arith_ovf)
            return pack_basis(ax, ay, bx, by, steps, ERR_OVF);
        if (r0 == 0 && p0 == 0)
        begin
            t1x = r1;
            t1y = p1;
        end
        else
        begin
            // Final quotient step: keep the shorter of two candidates
            if (sgnl(p0) * sgnl(p1) <= 0)
                divd = clip(clip(absl(r1)) - clip(absl(p1)));
            else
                divd = clip(clip(absl(p1)) - clip(absl(r1)));
            disr = clip(clip(absl(p0)) + clip(absl(r0)));
            if (arith_ovf)
                return pack_basis(ax, ay, bx, by, steps, ERR_OVF);
            if (disr == 0)
                return pack_basis(ax, ay, bx, by, steps, ERR_DIV0);
            q = divc(divd, disr);
            t1x = clip(r1 - mulc(q, r0));
            t1y = clip(p1 - mulc(q, p0));
            if (q >= 0)
            begin
                t2x = clip(t1x - r0);
                t2y = clip(t1y - p0);
            end
            else
            begin
                t2x = clip(t1x + r0);
                t2y = clip(t1y + p0);
            end
            if (arith_ovf)
                return pack_basis(ax, ay, bx, by, steps, ERR_OVF);
            m1 = absl(t1x) >= absl(t1y) ? absl(t1x) : absl(t1y);
            m2 = absl(t2x) >= absl(t2y) ? absl(t2x) : absl(t2y);
            if (m1 > m2)
            begin
                t1x = t2x;
                t1y = t2y;
            end
        end
        return pack_basis(r0, p0, t1x, t1y, steps, ERR_OK);
    endfunction

    assign pending_count = expected_bases.size();

    // Predict on each accepted input word, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        reduced_basis_t exp_b;
        if (!rst_n)
        begin
            expected_bases.delete();
            fail_count <= 0;
            basis_count <= 0;
            for (int i = 0; i < 4; i++)
                err_seen[i] <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_bases.push_back(reduce_basis(vec_a_x, vec_a_y, vec_b_x, vec_b_y));
            if (out_valid && !out_stall)
            begin
                basis_count <= basis_count + 1;
                if (expected_bases.size() == 0)
                begin
                    $error("unexpected result word");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_b = expected_bases.pop_front();
                    err_seen[exp_b.err] <= err_seen[exp_b.err] + 1;
                    if (red_a_x !== exp_b.ax || red_a_y !== exp_b.ay ||
                        red_b_x !== exp_b.bx || red_b_y !== exp_b.by ||
                        step_count !== exp_b.steps || error_code !== exp_b.err)
                        fail_count <= fail_count + 1;
                    if (red_a_x !== exp_b.ax)
                        $error("red_a_x expected %0d got %0d", exp_b.ax, red_a_x);
                    if (red_a_y !== exp_b.ay)
                        $error("red_a_y expected %0d got %0d", exp_b.ay, red_a_y);
                    if (red_b_x !== exp_b.bx)
                        $error("red_b_x expected %0d got %0d", exp_b.bx, red_b_x);
                    if (red_b_y !== exp_b.by)
                        $error("red_b_y expected %0d got %0d", exp_b.by, red_b_y);
                    if (step_count !== exp_b.steps)
                        $error("step_count expected %0d got %0d", exp_b.steps, step_count);
                    if (error_code !== exp_b.err)
                        $error("error_code expected %0d got %0d", exp_b.err, error_code);
                end
            end
        end
    end

endmodule

### dv/tb_lattice2d_partial_euclid_reduce_core.sv
// Testbench top for the 2D lattice reducer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_lattice2d_partial_euclid_reduce_core;
    import l2pe_pkg::*;

    localparam int RANDOM_BASES = 270;

    logic clk;
    logic rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [IO_WIDTH-1:0] vec_a_x, vec_a_y, vec_b_x, vec_b_y;
    logic signed [IO_WIDTH-1:0] red_a_x, red_a_y, red_b_x, red_b_y;
    logic [7:0] step_count;
    logic [1:0] error_code;
    int fail_count, pending_count, basis_count;
    int err_seen [4];
    int send_idle_pct, recv_stall_pct;
    bit hold_off;

    lattice2d_partial_euclid_reduce_core u_dut (.*);

    l2pe_checker u_checker (.*);

    initial clk = 0;
    always #6 clk = ~clk;

    // Bound the run well beyond the slowest legal schedule
    initial
    begin
        #400ms;
        $display("TEST FAILED");
        $finish;
    end

    // Stall the result side, with one long hold-off on request
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $signed($urandom_range(40)) - 20;
            2: return $signed($urandom_range(2000)) - 1000;
            3: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                         : 32'sh80000000 + $urandom_range(3);
            default: return $signed($urandom_range(200000)) - 100000;
        endcase
    endfunction

    // Offer one basis word and hold it until taken; in_stall is stable
    // from the falling edge up to the next rising edge
    task automatic send_basis(logic signed [31:0] ax, ay, bx, by);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        vec_a_x <= ax;
        vec_a_y <= ay;
        vec_b_x <= bx;
        vec_b_y <= by;
        while (in_stall)
            @(negedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        hold_off = 0;
        vec_a_x = 0; vec_a_y = 0; vec_b_x = 0; vec_b_y = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: reduced, zero coordinates, extremes, Euclid runs
        send_basis(0, 0, 0, 0);
        send_basis(5, 1, 1, 7);
        send_basis(3, -1, 1, 4);
        send_basis(0, 1, 1, 0);
        send_basis(4, 2, 0, 0);
        send_basis(0, 0, 3, 5);
        send_basis(7, 3, 5, 2);
        send_basis(100, 37, 61, 22);
        send_basis(-9, -4, -7, -3);
        send_basis(6, 4, 9, 6);
        send_basis(10, 10, 10, 10);
        send_basis(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7ffffffe);
        send_basis(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000001);
        send_basis(32'sh80000000, 1, 1, 32'sh80000000);
        send_basis(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_basis(32'sh80000001, 32'sh80000000, 32'sh7fffffff, 32'sh7ffffffe);
        send_basis(2, 1, 4, 2);
        send_basis(-1, -1, -1, -1);
        send_basis(1, 0, 0, 0);
        send_basis(1234567, 7654321, 1000003, 6200009);

        // Random phases with varying idle and stall mix
        for (int i = 0; i < RANDOM_BASES; i++)
        begin
            case (i / 54)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (i == 120)
            begin
                hold_off = 1;
                fork
                    begin
                        repeat (3000) @(negedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            send_basis(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
        in_valid <= 1'b0;

        // Drain, then allow a quiet tail
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        $display("Reduced %0d bases: ok %0d, div-by-zero %0d, step limit %0d, overflow %0d",
                 basis_count, err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
rtl/l2pe_pkg.sv
rtl/l2pe_div.sv
rtl/l2pe_datapath.sv
rtl/l2pe_ctrl.sv
rtl/lattice2d_partial_euclid_reduce_core.sv
dv/l2pe_checker.sv
dv/tb_lattice2d_partial_euclid_reduce_core.sv
